// File: hdl/spq_pkg.sv
package spq_pkg;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CLEAR   = 2'd3
    } spq_opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } spq_status_t;

    // Operation broadcast to every cell, already qualified by the fill level.
    typedef struct packed {
        logic enq;
        logic deq;
        logic clr;
    } spq_ctrl_t;

endpackage

// File: hdl/spq_cell.sv
module spq_cell #(
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  spq_pkg::spq_ctrl_t       ctrl,
    input  logic [VALUE_BITS-1:0]    new_value,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic                     prev_after,
    input  logic [VALUE_BITS-1:0]    prev_value,
    input  logic [PRIORITY_BITS-1:0] prev_prio,
    input  logic                     prev_valid,
    input  logic [VALUE_BITS-1:0]    next_value,
    input  logic [PRIORITY_BITS-1:0] next_prio,
    input  logic                     next_valid,
    output logic [VALUE_BITS-1:0]    value,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic                     valid,
    output logic                     after
);
    import spq_pkg::*;

    logic [VALUE_BITS-1:0]    value_reg, value_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic                     valid_reg, valid_next;

    // A new entry goes behind this cell when the cell holds an entry of equal
    // or higher urgency, which keeps equal priorities in arrival order.
    assign after = valid_reg && ($signed(prio_reg) <= $signed(new_prio));

    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        valid_next = valid_reg;
        priority if (ctrl.clr) begin
            valid_next = 1'b0;
        end else if (ctrl.enq && !after) begin
            if (prev_after) begin
                value_next = new_value;
                prio_next  = new_prio;
                valid_next = 1'b1;
            end else begin
                value_next = prev_value;
                prio_next  = prev_prio;
                valid_next = prev_valid;
            end
        end else if (ctrl.deq) begin
            value_next = next_value;
            prio_next  = next_prio;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign prio  = prio_reg;
    assign valid = valid_reg;

endmodule

// File: hdl/stable_sorted_priority_queue_unit.sv
// A result word is registered and appears in the cycle after its input is
// accepted. One word per cycle goes in unless m_tready low stalls the output;
// cells compare to the new priority in parallel and shift in a single step.
// Reset (aresetn low, synchronous) empties the queue and the result register
// at once; no clearing pass follows, the block takes a word right after reset.
module stable_sorted_priority_queue_unit #(
    parameter int DEPTH         = 16,
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // Fields from bit 0: item_value, item_priority, zero fill.
    input  logic [((VALUE_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0: opcode.
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // Fields from bit 0: head_value, entry_count, zero fill.
    output logic [((VALUE_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // Fields from bit 0: status.
    output logic [1:0] m_tuser
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((VALUE_BITS + CNT_W + 7) / 8) * 8;

    logic [VALUE_BITS-1:0]    in_value;
    logic [PRIORITY_BITS-1:0] in_prio;
    spq_opcode_t              in_op;
    logic                     accept;

    logic [VALUE_BITS-1:0]    chain_value [DEPTH+2];
    logic [PRIORITY_BITS-1:0] chain_prio  [DEPTH+2];
    logic                     chain_valid [DEPTH+2];
    logic [DEPTH:0]           after_chain;
    logic [DEPTH-1:0]         valid_vec;

    spq_ctrl_t   ctrl;
    logic        is_empty;
    logic        is_full;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [VALUE_BITS-1:0] head_reg, head_next;
    spq_status_t           status_reg, status_next;

    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign in_prio  = s_tdata[VALUE_BITS+PRIORITY_BITS-1:VALUE_BITS];
    assign in_op    = spq_opcode_t'(s_tuser);

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        ctrl.enq = accept && (in_op == OP_ENQUEUE) && !is_full;
        ctrl.deq = accept && (in_op == OP_DEQUEUE) && !is_empty;
        ctrl.clr = accept && (in_op == OP_CLEAR);
    end

    // The ends of the row: the head sees a boundary that every entry stands
    // behind, and the tail pulls in an empty slot on a dequeue.
    assign chain_value[0]       = '0;
    assign chain_prio[0]        = '0;
    assign chain_valid[0]       = 1'b0;
    assign chain_value[DEPTH+1] = '0;
    assign chain_prio[DEPTH+1]  = '0;
    assign chain_valid[DEPTH+1] = 1'b0;
    assign after_chain[0]       = 1'b1;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_cell #(
            .VALUE_BITS   (VALUE_BITS),
            .PRIORITY_BITS(PRIORITY_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_value  (in_value),
            .new_prio   (in_prio),
            .prev_after (after_chain[i]),
            .prev_value (chain_value[i]),
            .prev_prio  (chain_prio[i]),
            .prev_valid (chain_valid[i]),
            .next_value (chain_value[i+2]),
            .next_prio  (chain_prio[i+2]),
            .next_valid (chain_valid[i+2]),
            .value      (chain_value[i+1]),
            .prio       (chain_prio[i+1]),
            .valid      (chain_valid[i+1]),
            .after      (after_chain[i+1])
        );
        assign valid_vec[i] = chain_valid[i+1];
    end

    always_comb begin
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        head_next     = head_reg;
        status_next   = status_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            head_next     = '0;
            status_next   = ST_OK;
            unique case (in_op)
                OP_ENQUEUE: begin
                    if (is_full) begin
                        status_next = ST_FULL;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_DEQUEUE: begin
                    if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        head_next  = chain_value[1];
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_PEEK: begin
                    if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        head_next = chain_value[1];
                    end
                end
                OP_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        head_reg   <= head_next;
        status_reg <= status_next;
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({count_reg, head_reg});
    assign m_tuser  = status_reg;

    // The fill count must always agree with the occupied cells.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
    else $error("fill count differs from occupied cells");

    // Occupied cells form an unbroken run starting at the head.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, valid_vec} + (DEPTH+1)'(1)))
    else $error("occupied cells are not contiguous from the head");

    // A refused enqueue is only reported when the row is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (status_reg == ST_FULL)) |-> (count_reg == CNT_W'(DEPTH)))
    else $error("full status reported below capacity");

    // A reported empty queue leaves the count at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (status_reg == ST_EMPTY)) |-> (count_reg == '0))
    else $error("empty status reported with entries held");

    // No result word is pending in the cycle after reset.
    assert property (@(posedge aclk) $past(!aresetn) |-> !m_tvalid_reg)
    else $error("result word pending after reset");

endmodule
